// ----- design/tfvn_pkg.sv -----
// ----------------------------------------------------------------------------
// tfvn_pkg
// shared types, constants and helper functions of the fractal value noise
// ----------------------------------------------------------------------------
package tfvn_pkg;

   localparam int MaxOctaves    = 8;
   localparam int OctIdxW       = $clog2(MaxOctaves);
   localparam int CoordW        = 32;
   localparam int CoordFracBits = 16;
   localparam int IntW          = CoordW - CoordFracBits;
   localparam int FracW         = 16;
   localparam int PeriodW       = 16;
   localparam int CountW        = 4;
   localparam int PersW         = 16;
   localparam int SeedW         = 32;
   localparam int HashW         = 32;
   localparam int ValW          = 24;
   // period scaled by up to 2^(MaxOctaves-1)
   localparam int SpanW         = PeriodW + MaxOctaves - 1;
   localparam int AmpW          = 17;
   localparam int NormW         = AmpW + OctIdxW;
   localparam int TotW          = ValW + AmpW + OctIdxW;
   localparam int SmoothW       = 17;
   localparam int ModBits       = IntW;
   localparam int DivBits       = ValW;
   localparam int CellStages    = 7;

   localparam logic [HashW-1:0] HashMulX   = 32'd374761393;
   localparam logic [HashW-1:0] HashMulY   = 32'd668265263;
   localparam logic [HashW-1:0] HashMulS   = 32'd2246822519;
   localparam logic [HashW-1:0] HashMulM   = 32'd1274126177;
   localparam logic [AmpW-1:0]  AmpOne     = 17'h10000;
   localparam logic [17:0]      SmoothThree = 18'd196608;

   typedef enum logic [1:0] {
      CSR_TILE_PERIOD  = 2'd0,
      CSR_OCTAVE_COUNT = 2'd1,
      CSR_PERSISTENCE  = 2'd2,
      CSR_NOISE_SEED   = 2'd3
   } csr_index_type;

   // point as it enters the wrap unit
   typedef struct packed {
      logic              valid;
      logic [IntW-1:0]   int_x;
      logic [IntW-1:0]   int_y;
      logic [FracW-1:0]  frac_x;
      logic [FracW-1:0]  frac_y;
   } front_type;

   typedef struct packed {
      logic             neg;
      logic [IntW-1:0]  mag;
      logic [IntW-1:0]  rem;
   } mod_lane_type;

   typedef struct packed {
      logic             valid;
      mod_lane_type     lane_x;
      mod_lane_type     lane_y;
      logic [FracW-1:0] frac_x;
      logic [FracW-1:0] frac_y;
   } mod_st_type;

   // request as it travels down the octave chain
   typedef struct packed {
      logic             valid;
      logic [FracW-1:0] frac_x;
      logic [FracW-1:0] frac_y;
      logic [IntW-1:0]  wrap_x;
      logic [IntW-1:0]  wrap_y;
      logic [TotW-1:0]  total;
      logic [NormW-1:0] norm;
      logic [AmpW-1:0]  amp;
   } chain_type;

   typedef struct packed {
      logic             valid;
      logic [TotW-1:0]  rem;
      logic [NormW-1:0] norm;
      logic [ValW-1:0]  quo;
   } div_st_type;

   // one restoring remainder step, msb of the magnitude first
   function automatic mod_lane_type mod_step(mod_lane_type l, logic [PeriodW-1:0] per);
      logic [IntW:0] cur;
      mod_lane_type  r;
      cur    = {l.rem, l.mag[IntW-1]};
      r      = l;
      r.mag  = {l.mag[IntW-2:0], 1'b0};
      if (cur >= {1'b0, per}) begin
         r.rem = IntW'(cur - {1'b0, per});
      end else begin
         r.rem = cur[IntW-1:0];
      end
      return r;
   endfunction

   // a*(1-s) + b*s with s in q1.16
   function automatic logic [ValW-1:0] blend(logic [ValW-1:0] a, logic [ValW-1:0] b,
                                             logic [SmoothW-1:0] s);
      logic [ValW+SmoothW:0] acc;
      acc = (ValW+SmoothW+1)'(a) * (ValW+SmoothW+1)'(AmpOne - s)
          + (ValW+SmoothW+1)'(b) * (ValW+SmoothW+1)'(s);
      return acc[ValW+15:16];
   endfunction

   function automatic logic [ValW-1:0] hash_finish(logic [HashW-1:0] h);
      logic [HashW-1:0] t;
      t = h ^ (h >> 16);
      return t[ValW-1:0];
   endfunction

endpackage

// ----- design/tileable_fractal_value_noise.sv -----
// ----------------------------------------------------------------------------
// tileable_fractal_value_noise
// tileable 2-d fractal value noise, one q16.16 point in, one q0.24 value out
// ----------------------------------------------------------------------------
// The block takes one request per clock while the output is not stalled and
// returns one noise value per request, in order, through the wrap unit (a
// 16-step bit-serial remainder of the integer coordinates by the tile period
// plus a sign fixup), 8 octave cells of 7 stages each, and a bit-per-stage
// division by the weight sum, whose last stage is the output register. Every
// octave cell is built even when fewer octaves are enabled; disabled cells
// pass the running sums through. When a result is held on the output, the
// whole pipeline holds, so req_ready follows rsp_ready while a result is
// waiting. The user is to write registers through the csr port only while no
// request is in flight; the block does not enforce it. Cells read them live.
// ----------------------------------------------------------------------------
module tileable_fractal_value_noise (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [31:0]              req_point_x,
   input  logic signed [31:0]              req_point_y,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [23:0]                     rsp_noise_value,
   input  logic                            csr_write_en,
   input  logic [1:0]                      csr_index,
   input  logic [31:0]                     csr_wdata
);
   import tfvn_pkg::*;

   // configuration registers
   logic [PeriodW-1:0] tile_period_ff;
   logic [CountW-1:0]  octave_count_ff;
   logic [PersW-1:0]   persistence_ff;
   logic [SeedW-1:0]   noise_seed_ff;
   logic [PeriodW-1:0] per_eff;

   logic       enable;
   front_type  front;
   chain_type  chain [MaxOctaves+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_period_ff  <= PeriodW'(1);
         octave_count_ff <= CountW'(4);
         persistence_ff  <= PersW'(32768);
         noise_seed_ff   <= '0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_TILE_PERIOD:  tile_period_ff  <= csr_wdata[PeriodW-1:0];
            CSR_OCTAVE_COUNT: octave_count_ff <= csr_wdata[CountW-1:0];
            CSR_PERSISTENCE:  persistence_ff  <= csr_wdata[PersW-1:0];
            CSR_NOISE_SEED:   noise_seed_ff   <= csr_wdata[SeedW-1:0];
            default: ;
         endcase
      end
   end

   // a zero period means a period of one
   assign per_eff = (tile_period_ff == '0) ? PeriodW'(1) : tile_period_ff;

   // whole pipeline moves unless a finished result is stuck at the output
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   // split the point into floor and q0.16 fraction
   always_comb begin
      front.valid  = req_valid && req_ready;
      front.int_x  = req_point_x[CoordW-1:CoordFracBits];
      front.int_y  = req_point_y[CoordW-1:CoordFracBits];
      front.frac_x = req_point_x[CoordFracBits-1:0];
      front.frac_y = req_point_y[CoordFracBits-1:0];
   end

   tfvn_wrap_mod u_wrap (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .per       (per_eff),
      .front_in  (front),
      .chain_out (chain[0])
   );

   // one cell per octave, each handing its running sums to the next
   for (genvar g = 0; g < MaxOctaves; g++) begin : g_octave
      tfvn_octave_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .enable       (enable),
         .octave_idx   (OctIdxW'(g)),
         .per          (per_eff),
         .octave_count (octave_count_ff),
         .persistence  (persistence_ff),
         .noise_seed   (noise_seed_ff),
         .chain_in     (chain[g]),
         .chain_out    (chain[g+1])
      );
   end

   tfvn_norm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .chain_in  (chain[MaxOctaves]),
      .out_valid (rsp_valid),
      .out_value (rsp_noise_value)
   );

endmodule

// ----- design/tfvn_wrap_mod.sv -----
// ----------------------------------------------------------------------------
// tfvn_wrap_mod
// pipelined true modulo of the integer lattice coordinates by the period
// ----------------------------------------------------------------------------
module tfvn_wrap_mod (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              enable,
   input  logic [tfvn_pkg::PeriodW-1:0]      per,
   input  tfvn_pkg::front_type               front_in,
   output tfvn_pkg::chain_type               chain_out
);
   import tfvn_pkg::*;

   mod_st_type st_ff [ModBits];
   mod_st_type st_in [ModBits];
   mod_st_type first;
   chain_type  chain_ff;
   chain_type  chain_in;

   always_comb begin
      first.valid       = front_in.valid;
      first.frac_x      = front_in.frac_x;
      first.frac_y      = front_in.frac_y;
      first.lane_x.neg  = front_in.int_x[IntW-1];
      first.lane_x.mag  = front_in.int_x[IntW-1] ? IntW'(-front_in.int_x) : front_in.int_x;
      first.lane_x.rem  = '0;
      first.lane_y.neg  = front_in.int_y[IntW-1];
      first.lane_y.mag  = front_in.int_y[IntW-1] ? IntW'(-front_in.int_y) : front_in.int_y;
      first.lane_y.rem  = '0;
      for (int k = 0; k < ModBits; k++) begin
         st_in[k] = (k == 0) ? first : st_ff[k-1];
         st_in[k].lane_x = mod_step(st_in[k].lane_x, per);
         st_in[k].lane_y = mod_step(st_in[k].lane_y, per);
      end
   end

   // negative inputs fold back into [0, per)
   always_comb begin
      chain_in.valid  = st_ff[ModBits-1].valid;
      chain_in.frac_x = st_ff[ModBits-1].frac_x;
      chain_in.frac_y = st_ff[ModBits-1].frac_y;
      chain_in.wrap_x = (st_ff[ModBits-1].lane_x.neg && st_ff[ModBits-1].lane_x.rem != '0)
                        ? per - st_ff[ModBits-1].lane_x.rem : st_ff[ModBits-1].lane_x.rem;
      chain_in.wrap_y = (st_ff[ModBits-1].lane_y.neg && st_ff[ModBits-1].lane_y.rem != '0)
                        ? per - st_ff[ModBits-1].lane_y.rem : st_ff[ModBits-1].lane_y.rem;
      chain_in.total  = '0;
      chain_in.norm   = '0;
      chain_in.amp    = AmpOne;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ModBits; k++) begin
            st_ff[k].valid <= 1'b0;
         end
         chain_ff.valid <= 1'b0;
      end else if (enable) begin
         for (int k = 0; k < ModBits; k++) begin
            st_ff[k] <= st_in[k];
         end
         chain_ff <= chain_in;
      end
   end

   assign chain_out = chain_ff;

endmodule

// ----- design/tfvn_octave_cell.sv -----
// ----------------------------------------------------------------------------
// tfvn_octave_cell
// one octave: lattice corners, hashes, smoothstep blend, weighted accumulate
// ----------------------------------------------------------------------------
module tfvn_octave_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              enable,
   input  logic [tfvn_pkg::OctIdxW-1:0]      octave_idx,
   input  logic [tfvn_pkg::PeriodW-1:0]      per,
   input  logic [tfvn_pkg::CountW-1:0]       octave_count,
   input  logic [tfvn_pkg::PersW-1:0]        persistence,
   input  logic [tfvn_pkg::SeedW-1:0]        noise_seed,
   input  tfvn_pkg::chain_type               chain_in,
   output tfvn_pkg::chain_type               chain_out
);
   import tfvn_pkg::*;

   chain_type c_ff [CellStages];
   chain_type c6_in;

   logic [SpanW-1:0]   span;
   logic [SpanW-1:0]   x0_in, x1_in, y0_in, y1_in;
   logic [FracW-1:0]   fx_in, fy_in;
   logic [SpanW-1:0]   x0_ff, x1_ff, y0_ff, y1_ff;
   logic [FracW-1:0]   fx_ff, fy_ff;
   logic [4:0]         lo_shift;

   logic [HashW-1:0]   mx0_ff, mx1_ff, my0_ff, my1_ff, ms_ff, seed;
   logic [31:0]        t2x_ff, t2y_ff;
   logic [17:0]        kx_ff, ky_ff;

   logic [HashW-1:0]   h_ff [4];
   logic [49:0]        smx_prod, smy_prod;
   logic [SmoothW-1:0] sx_ff, sy_ff, sx3_ff, sy3_ff, sy4_ff;

   logic [HashW-1:0]   hm_ff [4];
   logic [ValW-1:0]    top_ff, bot_ff, v_ff;
   logic               active;
   logic [AmpW+PersW-1:0] amp_prod;

   assign span     = SpanW'(per) << octave_idx;
   assign lo_shift = 5'(FracW) - 5'(octave_idx);

   // corners: wrapped integer part scaled up, low bits come from the fraction
   always_comb begin
      x0_in = (SpanW'(chain_in.wrap_x) << octave_idx) | SpanW'(chain_in.frac_x >> lo_shift);
      y0_in = (SpanW'(chain_in.wrap_y) << octave_idx) | SpanW'(chain_in.frac_y >> lo_shift);
      x1_in = (SpanW'(x0_in + 1'b1) == span) ? '0 : SpanW'(x0_in + 1'b1);
      y1_in = (SpanW'(y0_in + 1'b1) == span) ? '0 : SpanW'(y0_in + 1'b1);
      fx_in = FracW'(chain_in.frac_x << octave_idx);
      fy_in = FracW'(chain_in.frac_y << octave_idx);
   end

   // octave seed is base + 101*i, done as shift-add
   assign seed = noise_seed + HashW'({octave_idx, 6'b0}) + HashW'({octave_idx, 5'b0})
               + HashW'({octave_idx, 2'b0}) + HashW'(octave_idx);

   assign smx_prod = 50'(t2x_ff) * 50'(kx_ff);
   assign smy_prod = 50'(t2y_ff) * 50'(ky_ff);

   assign active   = octave_count > CountW'(octave_idx);
   assign amp_prod = (AmpW+PersW)'(c_ff[5].amp) * (AmpW+PersW)'(persistence);

   always_comb begin
      c6_in = c_ff[5];
      if (active) begin
         c6_in.total = c_ff[5].total + TotW'(TotW'(v_ff) * TotW'(c_ff[5].amp));
         c6_in.norm  = c_ff[5].norm + NormW'(c_ff[5].amp);
         c6_in.amp   = amp_prod[AmpW+15:16];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x0_ff <= x0_in;
         x1_ff <= x1_in;
         y0_ff <= y0_in;
         y1_ff <= y1_in;
         fx_ff <= fx_in;
         fy_ff <= fy_in;
         mx0_ff <= HashW'(x0_ff) * HashMulX;
         mx1_ff <= HashW'(x1_ff) * HashMulX;
         my0_ff <= HashW'(y0_ff) * HashMulY;
         my1_ff <= HashW'(y1_ff) * HashMulY;
         ms_ff  <= seed * HashMulS;
         t2x_ff <= 32'(fx_ff) * 32'(fx_ff);
         t2y_ff <= 32'(fy_ff) * 32'(fy_ff);
         kx_ff  <= SmoothThree - 18'({fx_ff, 1'b0});
         ky_ff  <= SmoothThree - 18'({fy_ff, 1'b0});
         h_ff[0] <= mx0_ff + my0_ff + ms_ff;
         h_ff[1] <= mx1_ff + my0_ff + ms_ff;
         h_ff[2] <= mx0_ff + my1_ff + ms_ff;
         h_ff[3] <= mx1_ff + my1_ff + ms_ff;
         sx_ff  <= smx_prod[SmoothW+31:32];
         sy_ff  <= smy_prod[SmoothW+31:32];
         for (int k = 0; k < 4; k++) begin
            hm_ff[k] <= (h_ff[k] ^ (h_ff[k] >> 13)) * HashMulM;
         end
         sx3_ff <= sx_ff;
         sy3_ff <= sy_ff;
         top_ff <= blend(hash_finish(hm_ff[0]), hash_finish(hm_ff[1]), sx3_ff);
         bot_ff <= blend(hash_finish(hm_ff[2]), hash_finish(hm_ff[3]), sx3_ff);
         sy4_ff <= sy3_ff;
         v_ff   <= blend(top_ff, bot_ff, sy4_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CellStages; k++) begin
            c_ff[k].valid <= 1'b0;
         end
      end else if (enable) begin
         c_ff[0] <= chain_in;
         for (int k = 1; k < CellStages - 1; k++) begin
            c_ff[k] <= c_ff[k-1];
         end
         c_ff[CellStages-1] <= c6_in;
      end
   end

   assign chain_out = c_ff[CellStages-1];

endmodule

// ----- design/tfvn_norm_div.sv -----
// ----------------------------------------------------------------------------
// tfvn_norm_div
// pipelined restoring division of the weighted sum by the weight sum
// ----------------------------------------------------------------------------
module tfvn_norm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  tfvn_pkg::chain_type           chain_in,
   output logic                          out_valid,
   output logic [tfvn_pkg::ValW-1:0]     out_value
);
   import tfvn_pkg::*;

   div_st_type st_ff [DivBits];
   div_st_type st_in [DivBits];
   div_st_type src;
   logic [TotW-1:0] shifted;

   always_comb begin
      shifted = '0;
      for (int k = 0; k < DivBits; k++) begin
         if (k == 0) begin
            src.valid = chain_in.valid;
            src.rem   = chain_in.total;
            src.norm  = chain_in.norm;
            src.quo   = '0;
         end else begin
            src = st_ff[k-1];
         end
         shifted  = TotW'(src.norm) << (DivBits - 1 - k);
         st_in[k] = src;
         if (src.rem >= shifted) begin
            st_in[k].rem                  = src.rem - shifted;
            st_in[k].quo[DivBits - 1 - k] = 1'b1;
         end
         // no active octave: result is zero
         if (k == DivBits - 1 && src.norm == '0) begin
            st_in[k].quo = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DivBits; k++) begin
            st_ff[k].valid <= 1'b0;
         end
      end else if (enable) begin
         for (int k = 0; k < DivBits; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign out_valid = st_ff[DivBits-1].valid;
   assign out_value = st_ff[DivBits-1].quo;

endmodule

// ----- design/tfvn_checker.sv -----
// ----------------------------------------------------------------------------
// tfvn_port_props
// port-level checks on the noise block, bound to the top level
// ----------------------------------------------------------------------------
module tfvn_port_props (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] rsp_noise_value
);

   // a response waiting at the output stays
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // no response in the cycle after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid right after reset");

   // an empty output never blocks requests
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output");

   // a stalled pipeline takes no request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while output stalled");

   // stalled result keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_noise_value))
      else $error("rsp_noise_value changed while stalled");

endmodule

bind tileable_fractal_value_noise tfvn_port_props u_checker (.*);
